// File: rtl/core/mbpm_pkg.sv
// Shared types and constants of the masked byte pattern matcher.
`timescale 1ns / 1ps

package mbpm_pkg;

    localparam int REG_BYTES = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [1:0] CFG_CARE_MASK    = 2'd2;
    localparam logic [1:0] CFG_PATTERN_LEN  = 2'd3;

    // Match count codes
    localparam logic [1:0] MATCH_NONE = 2'd0;
    localparam logic [1:0] MATCH_ONE  = 2'd1;
    localparam logic [1:0] MATCH_MANY = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  match_count;
        logic [31:0] first_offset;
    } t_out_beat;

    typedef struct packed {
        logic [8*REG_BYTES-1:0] pattern;
        logic [REG_BYTES-1:0]   care;
        logic [4:0]             length;
    } t_cfg;

    typedef struct packed {
        logic       advance;
        logic       last_byte;
        logic [7:0] data_byte;
    } t_step;

endpackage

// File: rtl/core/masked_byte_pattern_matcher.sv
// Top level of the masked byte pattern matcher.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_beat) carries one stream byte
//   per beat, with last_byte set on the final byte of a stream. Output channel
//   (o_out_valid / i_out_ready / o_out_beat) carries one result per stream:
//   the match count (none, one, two or more) and the start offset of the first
//   match. Configuration channel (i_cfg_valid / o_cfg_ready, index, data) writes
//   pattern low and high words, the care mask and the pattern length; write it
//   only while no stream is in flight. It is always ready.
//   Throughput: one byte per cycle while no last byte waits for the result
//   register. The window compare is one parallel masked compare of the input
//   and window registers against the configured pattern bytes.
//   Reset clears the window, counters, pattern length back to one and both
//   valid flags. When the receiver stalls, the result register holds and the
//   input register keeps taking ordinary bytes; a last byte waits in the input
//   register until the result register frees up, and only then is ready low.
`timescale 1ns / 1ps

module masked_byte_pattern_matcher #(
    parameter int PATTERN_MAX  = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mbpm_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mbpm_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    logic               r_in_valid;
    mbpm_pkg::t_in_beat r_in;
    logic               consume;
    logic               hit;
    mbpm_pkg::t_cfg     cfg;
    mbpm_pkg::t_step    step;

    // A last byte advances only when the result register can take its result.
    assign consume    = r_in_valid && (!r_in.last_byte || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || consume;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        step.advance   = consume;
        step.last_byte = r_in.last_byte;
        step.data_byte = r_in.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_beat;
        end
    end

    mbpm_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbpm_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .o_hit   (hit)
    );

    mbpm_tracker #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_length    (cfg.length),
        .i_hit       (hit),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

// File: rtl/core/mbpm_cfg_regs.sv
// Configuration registers and clamped active pattern length.
`timescale 1ns / 1ps

module mbpm_cfg_regs #(
    parameter int PATTERN_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output mbpm_pkg::t_cfg    o_cfg
);

    localparam int LIMIT = (PATTERN_MAX < mbpm_pkg::REG_BYTES) ?
                           PATTERN_MAX : mbpm_pkg::REG_BYTES;
    localparam logic [4:0] LIMIT_LEN = 5'(LIMIT);

    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    logic [15:0] r_care;
    logic [4:0]  r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= 5'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbpm_pkg::CFG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                mbpm_pkg::CFG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                mbpm_pkg::CFG_CARE_MASK:    r_care   <= i_cfg_data[15:0];
                mbpm_pkg::CFG_PATTERN_LEN:  r_len    <= i_cfg_data[4:0];
            endcase
        end
    end

    always_comb begin
        o_cfg.pattern = {r_pat_hi, r_pat_lo};
        o_cfg.care    = r_care;
        o_cfg.length  = (r_len > LIMIT_LEN) ? LIMIT_LEN : r_len;
    end

endmodule

// File: rtl/core/mbpm_window.sv
// Recent-byte window and parallel masked compare against the pattern.
`timescale 1ns / 1ps

module mbpm_window #(
    parameter int PATTERN_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbpm_pkg::t_step   i_step,
    input  mbpm_pkg::t_cfg    i_cfg,
    output logic              o_hit
);

    localparam int WIN = (PATTERN_MAX < mbpm_pkg::REG_BYTES) ?
                         PATTERN_MAX : mbpm_pkg::REG_BYTES;

    logic [7:0]     r_win [WIN];
    logic [7:0]     shifted [WIN];
    logic [7:0]     pat_b [mbpm_pkg::REG_BYTES];
    logic [WIN-1:0] pos_ok;

    always_comb begin
        for (int k = 0; k < mbpm_pkg::REG_BYTES; k++) begin
            pat_b[k] = i_cfg.pattern[k*8 +: 8];
        end
        shifted[0] = i_step.data_byte;
        for (int k = 1; k < WIN; k++) begin
            shifted[k] = r_win[k-1];
        end
    end

    // Window slot i (0 newest) lines up with pattern byte length-1-i.
    always_comb begin
        logic [4:0] j;
        for (int i = 0; i < WIN; i++) begin
            j = i_cfg.length - 5'(i) - 5'd1;
            if (5'(i) < i_cfg.length) begin
                pos_ok[i] = !i_cfg.care[j[3:0]] || (shifted[i] == pat_b[j[3:0]]);
            end else begin
                pos_ok[i] = 1'b1;
            end
        end
    end

    assign o_hit = &pos_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) r_win[k] <= '0;
        end else if (i_step.advance) begin
            // drop the window at the end of each stream
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= i_step.last_byte ? 8'd0 : shifted[k];
            end
        end
    end

endmodule

// File: rtl/core/mbpm_tracker.sv
// Byte counter, match count and first offset, with the result register.
`timescale 1ns / 1ps

module mbpm_tracker #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbpm_pkg::t_step     i_step,
    input  logic [4:0]          i_length,
    input  logic                i_hit,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mbpm_pkg::t_out_beat o_out_beat
);

    logic [OFFSET_WIDTH-1:0] r_seen;
    logic [OFFSET_WIDTH-1:0] r_first;
    logic [1:0]              r_cnt;
    logic                    r_out_valid;
    mbpm_pkg::t_out_beat     r_out;

    logic [OFFSET_WIDTH-1:0] n_seen;
    logic [OFFSET_WIDTH-1:0] n_first;
    logic [1:0]              n_cnt;
    logic [OFFSET_WIDTH-1:0] len_ext;
    logic                    found;

    always_comb begin
        len_ext = OFFSET_WIDTH'(i_length);
        n_seen  = (r_seen == '1) ? r_seen : r_seen + 1'b1;
        found   = i_hit && (i_length != 5'd0) && (n_seen >= len_ext) &&
                  (r_cnt != mbpm_pkg::MATCH_MANY);
        n_cnt   = r_cnt;
        n_first = r_first;
        if (found) begin
            if (r_cnt == mbpm_pkg::MATCH_NONE) begin
                n_cnt   = mbpm_pkg::MATCH_ONE;
                n_first = n_seen - len_ext;
            end else begin
                n_cnt = mbpm_pkg::MATCH_MANY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_first     <= '0;
            r_cnt       <= mbpm_pkg::MATCH_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step.advance) begin
                if (i_step.last_byte) begin
                    r_seen  <= '0;
                    r_first <= '0;
                    r_cnt   <= mbpm_pkg::MATCH_NONE;
                end else begin
                    r_seen  <= n_seen;
                    r_first <= n_first;
                    r_cnt   <= n_cnt;
                end
            end
            if (i_step.advance && i_step.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.advance && i_step.last_byte) begin
            r_out.match_count  <= n_cnt;
            r_out.first_offset <= (n_cnt != mbpm_pkg::MATCH_NONE) ? 32'(n_first) : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// File: rtl/core/mbpm_checker.sv
// Port-level checks on the matcher's result channel, bound to the top level.
`timescale 1ns / 1ps

module mbpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mbpm_pkg::t_out_beat o_out_beat
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.match_count != 2'd3)
        else $error("match count out of range");

    a_no_match_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.match_count == mbpm_pkg::MATCH_NONE
        |-> o_out_beat.first_offset == 32'd0)
        else $error("nonzero offset without a match");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind masked_byte_pattern_matcher mbpm_checker u_mbpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

// File: verif/masked_byte_pattern_matcher_test.sv
// Testbench of the masked byte pattern matcher: directed table, then random streams.
`timescale 1ns / 1ps

module masked_byte_pattern_matcher_test;

    localparam int  WINDOW        = 16;
    localparam int  IDLE_PCT      = 9;
    localparam int  HOLD_LEN      = 150;
    localparam int  RANDOM_BYTES  = 750;
    localparam int  DRAIN_PHASE   = 4;
    localparam int  HOLD_PHASE    = 5;
    localparam int  STEADY_PHASE  = 6;
    localparam time TIMEOUT_NS    = 2_000_000;

    typedef struct {
        bit                  is_write;
        logic [1:0]          reg_index;
        logic [63:0]         reg_value;
        mbpm_pkg::t_in_beat  beat;
        bit                  has_want;
        mbpm_pkg::t_out_beat want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    mbpm_pkg::t_in_beat  in_beat;
    logic                out_valid;
    logic                out_ready;
    mbpm_pkg::t_out_beat out_beat;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [63:0]         cfg_data;

    // Shadow of the block: registers and per-stream state
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  plen;
    logic [7:0]  shadow_window [WINDOW];
    logic [31:0] stream_bytes_seen;
    logic [1:0]  hit_count;
    logic [31:0] first_hit_at;

    mbpm_pkg::t_out_beat match_reports_due [$];
    t_row                plan [$];

    bit steady;
    bit hold_request;
    int mismatches;
    int reports_checked;
    int bytes_sent;
    int streams_sent;
    int settings_done;

    masked_byte_pattern_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] pattern_at(input int j);
        return (j < 8) ? pat_lo[j*8 +: 8] : pat_hi[(j-8)*8 +: 8];
    endfunction

    function automatic void clear_stream_state();
        foreach (shadow_window[k]) shadow_window[k] = 8'h00;
        stream_bytes_seen = '0;
        hit_count         = mbpm_pkg::MATCH_NONE;
        first_hit_at      = '0;
    endfunction

    function automatic bit window_hit(input int n);
        for (int j = 0; j < n; j++)
            if (care[j] && shadow_window[n-1-j] != pattern_at(j)) return 1'b0;
        return 1'b1;
    endfunction

    // Advance the shadow by one byte; return 1 with the report on a last byte.
    function automatic bit scan_byte(input mbpm_pkg::t_in_beat beat,
                                     output mbpm_pkg::t_out_beat report);
        int n;
        n = (plen > WINDOW) ? WINDOW : int'(plen);
        for (int k = WINDOW - 1; k > 0; k--) shadow_window[k] = shadow_window[k-1];
        shadow_window[0] = beat.data_byte;
        if (stream_bytes_seen != '1) stream_bytes_seen++;
        if (n > 0 && stream_bytes_seen >= 32'(n) &&
            hit_count != mbpm_pkg::MATCH_MANY && window_hit(n)) begin
            if (hit_count == mbpm_pkg::MATCH_NONE) begin
                first_hit_at = stream_bytes_seen - 32'(n);
                hit_count    = mbpm_pkg::MATCH_ONE;
            end else begin
                hit_count = mbpm_pkg::MATCH_MANY;
            end
        end
        report = '0;
        if (!beat.last_byte) return 1'b0;
        report.match_count  = hit_count;
        report.first_offset = (hit_count != mbpm_pkg::MATCH_NONE) ? first_hit_at : '0;
        clear_stream_state();
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : check_reports
        mbpm_pkg::t_out_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            if (match_reports_due.size() == 0) begin
                flag_mismatch($sformatf("report with nothing due: count %0d offset %0d",
                    out_beat.match_count, out_beat.first_offset));
            end else begin
                want = match_reports_due.pop_front();
                reports_checked++;
                if (out_beat.match_count !== want.match_count)
                    flag_mismatch($sformatf("match_count %0d, want %0d",
                        out_beat.match_count, want.match_count));
                if (out_beat.first_offset !== want.first_offset)
                    flag_mismatch($sformatf("first_offset %0d, want %0d",
                        out_beat.first_offset, want.first_offset));
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : receiver
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d reports still due", match_reports_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input mbpm_pkg::t_in_beat beat, input bit typed,
                             input mbpm_pkg::t_out_beat typed_want);
        mbpm_pkg::t_out_beat predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge i_clk); while (!in_ready);
        bytes_sent++;
        if (beat.last_byte) streams_sent++;
        if (scan_byte(beat, predicted)) begin
            if (typed) predicted = typed_want;
            match_reports_due = {match_reports_due, predicted};
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (match_reports_due.size() != 0) @(negedge i_clk);
    endtask

    // Drain, then give the last byte's result path time to go quiet.
    task automatic settle();
        drain();
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            mbpm_pkg::CFG_PATTERN_LOW:  pat_lo = value;
            mbpm_pkg::CFG_PATTERN_HIGH: pat_hi = value;
            mbpm_pkg::CFG_CARE_MASK:    care   = value[15:0];
            mbpm_pkg::CFG_PATTERN_LEN:  plen   = value[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void plan_write(input logic [1:0] idx, input logic [63:0] value);
        t_row row;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        row.beat      = '0;
        row.has_want  = 1'b0;
        row.want      = '0;
        plan = {plan, row};
    endfunction

    function automatic void plan_byte(input logic [7:0] data, input bit last);
        t_row row;
        row.is_write       = 1'b0;
        row.reg_index      = mbpm_pkg::CFG_PATTERN_LOW;
        row.reg_value      = '0;
        row.beat.data_byte = data;
        row.beat.last_byte = last;
        row.has_want       = 1'b0;
        row.want           = '0;
        plan = {plan, row};
    endfunction

    function automatic void plan_last(input logic [7:0] data, input logic [1:0] count,
                                      input logic [31:0] offset);
        t_row row;
        row.is_write          = 1'b0;
        row.reg_index         = mbpm_pkg::CFG_PATTERN_LOW;
        row.reg_value         = '0;
        row.beat.data_byte    = data;
        row.beat.last_byte    = 1'b1;
        row.has_want          = 1'b1;
        row.want.match_count  = count;
        row.want.first_offset = offset;
        plan = {plan, row};
    endfunction

    task automatic pick_setting(input int phase);
        int          mode;
        logic [63:0] junk;
        logic [15:0] mask;
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        mode = (phase < 6) ? phase : $urandom_range(7);
        case (mode)
            0:       len = 5'd16;
            1:       len = 5'd1;
            2:       len = 5'($urandom_range(31, 17));
            3:       len = 5'd0;
            4:       len = 5'($urandom_range(1, 16));
            default: len = 5'($urandom_range(1, 5));
        endcase
        if (mode == 0)                 mask = 16'hFFFF;
        else if (mode == 3)            mask = 16'h0000;
        else if ($urandom_range(2) == 0) mask = 16'($urandom) & 16'($urandom);
        else                           mask = 16'($urandom);
        if (mode == 0) begin
            lo = '1;
            hi = '1;
        end else if (mode == 1) begin
            lo = '0;
            hi = '0;
        end else begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end
        // Junk in the unused upper bits must be dropped by the block
        junk = {$urandom, $urandom};
        write_reg(mbpm_pkg::CFG_PATTERN_LOW, lo);
        write_reg(mbpm_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(mbpm_pkg::CFG_CARE_MASK, {junk[63:16], mask});
        write_reg(mbpm_pkg::CFG_PATTERN_LEN, {junk[63:5], len});
        settings_done++;
    endtask

    // Mostly streams that carry the pattern once or more, some with one byte of a copy altered.
    task automatic send_stream();
        logic [7:0]          bytes_q [$];
        logic [7:0]          b;
        mbpm_pkg::t_in_beat  beat;
        mbpm_pkg::t_out_beat unused;
        int                  n;
        int                  flip;
        n = (plen > WINDOW) ? WINDOW : int'(plen);
        unused = '0;
        repeat ($urandom_range(0, 5)) bytes_q = {bytes_q, 8'($urandom)};
        if (n > 0 && $urandom_range(9) < 8) begin
            repeat ((n > 8) ? $urandom_range(1, 2) : $urandom_range(1, 3)) begin
                flip = ($urandom_range(4) == 0) ? int'($urandom_range(n - 1)) : -1;
                for (int j = 0; j < n; j++) begin
                    b = care[j] ? pattern_at(j) : 8'($urandom);
                    if (j == flip) b = b ^ 8'($urandom_range(1, 255));
                    bytes_q = {bytes_q, b};
                end
                repeat ($urandom_range(0, 3)) bytes_q = {bytes_q, 8'($urandom)};
            end
        end
        repeat ($urandom_range(0, 3)) bytes_q = {bytes_q, 8'($urandom)};
        if (bytes_q.size() == 0) bytes_q = {bytes_q, 8'($urandom)};
        foreach (bytes_q[i]) begin
            beat.data_byte = bytes_q[i];
            beat.last_byte = (i == bytes_q.size() - 1);
            send_byte(beat, 1'b0, unused);
        end
    endtask

    initial begin : stimulus
        int target;
        int phase;
        int streams;
        in_valid     = 1'b0;
        in_beat      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = mbpm_pkg::CFG_PATTERN_LOW;
        cfg_data     = '0;
        i_rst_n      = 1'b0;
        steady       = 1'b0;
        hold_request = 1'b0;
        pat_lo       = '0;
        pat_hi       = '0;
        care         = '0;
        plen         = 5'd1;
        clear_stream_state();

        // Reset setting: length one, nothing cared, so every byte matches
        plan_last(8'h00, mbpm_pkg::MATCH_ONE, 32'd0);
        plan_byte(8'hFF, 1'b0);
        plan_last(8'hA5, mbpm_pkg::MATCH_MANY, 32'd0);
        // Zero length never matches
        plan_write(mbpm_pkg::CFG_PATTERN_LEN, 64'd0);
        plan_last(8'h5A, mbpm_pkg::MATCH_NONE, 32'd0);
        // Zero pattern, both bytes cared: a one-byte stream is too short
        plan_write(mbpm_pkg::CFG_PATTERN_LEN, 64'd2);
        plan_write(mbpm_pkg::CFG_CARE_MASK, 64'h0003);
        plan_last(8'h00, mbpm_pkg::MATCH_NONE, 32'd0);
        plan_byte(8'h00, 1'b0);
        plan_last(8'h00, mbpm_pkg::MATCH_ONE, 32'd0);
        plan_write(mbpm_pkg::CFG_PATTERN_LOW, 64'h00FF);
        plan_byte(8'h33, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_last(8'h00, mbpm_pkg::MATCH_ONE, 32'd1);
        // Length above sixteen is taken as sixteen; first and last byte cared
        plan_write(mbpm_pkg::CFG_PATTERN_LOW, '1);
        plan_write(mbpm_pkg::CFG_PATTERN_HIGH, '1);
        plan_write(mbpm_pkg::CFG_CARE_MASK, 64'h8001);
        plan_write(mbpm_pkg::CFG_PATTERN_LEN, 64'd31);
        plan_byte(8'hFF, 1'b0);
        for (int k = 0; k < 14; k++) plan_byte(8'(k * 8'h13), 1'b0);
        plan_last(8'hFF, mbpm_pkg::MATCH_ONE, 32'd0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_write) begin
                settle();
                write_reg(plan[r].reg_index, plan[r].reg_value);
            end else begin
                send_byte(plan[r].beat, plan[r].has_want, plan[r].want);
            end
        end

        target = bytes_sent + RANDOM_BYTES;
        phase  = 0;
        while (bytes_sent < target || phase <= STEADY_PHASE) begin
            settle();
            pick_setting(phase);
            steady = (phase == STEADY_PHASE);
            if (phase == HOLD_PHASE) hold_request = 1'b1;
            if (phase == HOLD_PHASE || phase == STEADY_PHASE) streams = 12;
            else if (plen > 8)                                streams = $urandom_range(3, 6);
            else                                              streams = $urandom_range(4, 12);
            for (int s = 0; s < streams; s++) begin
                // Stop offering until every report is back
                if (phase == DRAIN_PHASE && s == streams / 2) drain();
                send_stream();
            end
            steady = 1'b0;
            phase++;
        end

        settle();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d bytes in %0d streams under %0d random register settings,",
            bytes_sent, streams_sent, settings_done);
        $display("checked %0d match reports, including a %0d-cycle result hold-off.",
            reports_checked, HOLD_LEN);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mbpm_pkg.sv
rtl/core/mbpm_cfg_regs.sv
rtl/core/mbpm_window.sv
rtl/core/mbpm_tracker.sv
rtl/core/masked_byte_pattern_matcher.sv
rtl/core/mbpm_checker.sv
verif/masked_byte_pattern_matcher_test.sv
